/* hw/rtl/mpq_pkg.sv */
// Package for the max priority queue: sizes, operation and status codes,
// and the word types that travel along the chain of sorting cells.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package mpq_pkg;

  // Number of cells, and so the number of keys the queue can hold.
  localparam int CAPACITY = 64;
  localparam int KEY_W    = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ECNT_W   = 7;

  // Operation codes on the func port.
  localparam logic FUNC_INSERT  = 1'b0;
  localparam logic FUNC_EXTRACT = 1'b1;

  // Status codes of a result word.
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic                    ins;
    logic                    ext;
    logic signed [KEY_W-1:0] key;
  } mpq_cmd_t;

  // What a cell shows to its neighbors.
  typedef struct packed {
    logic                    valid;
    logic                    place;
    logic signed [KEY_W-1:0] key;
  } mpq_link_t;

endpackage

`default_nettype wire

/* hw/rtl/mpq_cell.sv */
// One cell of the sorted chain: holds one key and its valid bit.
// Depends on mpq_pkg for the command and link word types.
`default_nettype none

module mpq_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mpq_pkg::mpq_cmd_t  cmd,
  input  wire mpq_pkg::mpq_link_t left,
  input  wire mpq_pkg::mpq_link_t right,
  output mpq_pkg::mpq_link_t      own
);

  logic                            valid;
  logic signed [mpq_pkg::KEY_W-1:0] key;
  logic                            place;

  // The new key belongs here or above when this cell is free or holds less.
  assign place = cmd.ins && (!valid || (cmd.key > key));

  always_comb begin
    own.valid = valid;
    own.place = place;
    own.key   = key;
  end

  // Insert shifts the smaller keys one cell down; extract shifts all up.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.ext) begin
      valid <= right.valid;
    end else if (place) begin
      valid <= left.place ? left.valid : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ext) begin
      key <= right.key;
    end else if (place) begin
      key <= left.place ? left.key : cmd.key;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/max_priority_queue.sv */
// Top level of the max priority queue: a chain of sorting cells, the
// fill count and the result register. Depends on mpq_pkg and mpq_cell.
//
// Usage: a command word (func, key) is taken at a rising edge with start
// high and busy low. func selects insert of key or extract of the largest
// key held. Every command gives one result word in the next cycle: done is
// high for exactly that cycle with status, max_key and entry_count.
// The cells stay sorted largest first, so cell zero always holds the
// maximum. Each cell compares the broadcast key with its own once per
// command and hands its key to a neighbor, so a new command can be taken
// in every cycle that busy is low.
// An insert into a full queue is dropped with status full; an extract from
// an empty queue reports status empty and max_key zero.
// Reset (synchronous, active high) empties the queue; busy is high while
// rst is high, so no command is taken during reset. The receiver cannot
// stall: each result word is shown for one cycle only.
`default_nettype none

module max_priority_queue (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            func,
  input  wire logic signed [mpq_pkg::KEY_W-1:0] key,
  output logic                                 done,
  output logic [1:0]                           status,
  output logic signed [mpq_pkg::KEY_W-1:0]     max_key,
  output logic [mpq_pkg::ECNT_W-1:0]           entry_count
);

  localparam int N = mpq_pkg::CAPACITY;

  mpq_pkg::mpq_cmd_t  cmd;
  mpq_pkg::mpq_link_t links [N];
  mpq_pkg::mpq_link_t lefts [N];
  mpq_pkg::mpq_link_t rights[N];

  logic                    accept;
  logic                    empty;
  logic                    full;
  logic [mpq_pkg::CNT_W-1:0] count;
  logic [mpq_pkg::CNT_W-1:0] count_next;
  logic [mpq_pkg::CNT_W+mpq_pkg::ECNT_W-1:0] count_wide;
  mpq_pkg::status_t        stat_next;

  assign busy   = rst;
  assign accept = start && !busy;
  assign empty  = !links[0].valid;
  assign full   = links[N-1].valid;

  // Gated command for the cells: drop inserts when full, extracts when empty.
  always_comb begin
    cmd.ins = accept && (func == mpq_pkg::FUNC_INSERT) && !full;
    cmd.ext = accept && (func == mpq_pkg::FUNC_EXTRACT) && !empty;
    cmd.key = key;
  end

  // Neighbor wiring with fixed ends: nothing above cell zero or below the last.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (i == 0) begin
        lefts[i] = '0;
      end else begin
        lefts[i] = links[i-1];
      end
      if (i == N - 1) begin
        rights[i] = '0;
      end else begin
        rights[i] = links[i+1];
      end
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    mpq_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .cmd   (cmd),
      .left  (lefts[g]),
      .right (rights[g]),
      .own   (links[g])
    );
  end

  // Status and count after the command.
  always_comb begin
    stat_next  = mpq_pkg::STAT_OK;
    count_next = count;
    if (func == mpq_pkg::FUNC_INSERT) begin
      if (full) begin
        stat_next = mpq_pkg::STAT_FULL;
      end else begin
        count_next = count + 1'b1;
      end
    end else begin
      if (empty) begin
        stat_next = mpq_pkg::STAT_EMPTY;
      end else begin
        count_next = count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // Result register, shown for one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= stat_next;
      if (cmd.ext) begin
        max_key <= links[0].key;
      end else begin
        max_key <= '0;
      end
    end
  end

  // The reported count keeps its low bits only.
  assign count_wide  = {{mpq_pkg::ECNT_W{1'b0}}, count};
  assign entry_count = count_wide[mpq_pkg::ECNT_W-1:0];

endmodule

`default_nettype wire

/* hw/rtl/mpq_checker.sv */
// Port-level checker for the max priority queue, bound to the top level.
// Depends on mpq_pkg for the status codes and the capacity.
`default_nettype none

module mpq_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            start,
  input wire logic                            busy,
  input wire logic                            done,
  input wire logic [1:0]                      status,
  input wire logic signed [mpq_pkg::KEY_W-1:0] max_key,
  input wire logic [mpq_pkg::ECNT_W-1:0]      entry_count
);

  localparam logic [mpq_pkg::ECNT_W-1:0] FULL_CNT = mpq_pkg::ECNT_W'(mpq_pkg::CAPACITY);

  // Every accepted word gives a result word in the next cycle.
  a_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("accepted word gave no result");

  // No result word appears without an accepted word.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("result word without a command");

  // An empty report carries zero key and zero count.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (done && status == mpq_pkg::STAT_EMPTY) |-> (max_key == '0 && entry_count == '0))
    else $error("empty report with nonzero fields");

  // A dropped insert is reported only when the queue is full.
  a_full: assert property (@(posedge clk) disable iff (rst)
    (done && status == mpq_pkg::STAT_FULL) |-> (max_key == '0 && entry_count == FULL_CNT))
    else $error("full report with wrong fields");

endmodule

bind max_priority_queue mpq_checker u_mpq_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .status      (status),
  .max_key     (max_key),
  .entry_count (entry_count)
);

`default_nettype wire

/* bench/mpq_checker.sv */
// Checker for the max priority queue: watches the command and result words,
// predicts every result from its own copy of the cells and compares them.
// Depends on mpq_pkg for sizes and the status codes.
module mpq_monitor (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             busy,
  input  logic                             func,
  input  logic signed [mpq_pkg::KEY_W-1:0] key,
  input  logic                             done,
  input  logic [1:0]                       status,
  input  logic signed [mpq_pkg::KEY_W-1:0] max_key,
  input  logic [mpq_pkg::ECNT_W-1:0]       entry_count,
  output int                               failures,
  output int                               pending,
  output int                               checked,
  output int                               empty_hits,
  output int                               full_hits,
  output int                               peak_fill
);
  timeunit 1ns;
  timeprecision 1ps;

  // One predicted result word.
  typedef struct packed {
    mpq_pkg::status_t                 st;
    logic signed [mpq_pkg::KEY_W-1:0] mk;
    logic [mpq_pkg::ECNT_W-1:0]       cnt;
  } queue_word_t;

  // Shadow copy of the cells: a key and a used flag each, plus the fill.
  logic signed [mpq_pkg::KEY_W-1:0] slot_key [mpq_pkg::CAPACITY];
  bit                               slot_used [mpq_pkg::CAPACITY];
  int                               fill;

  queue_word_t expected_words [$];
  int fail_total, checked_total, empty_total, full_total, peak_total;

  // Applies one command word to the shadow cells and returns its result.
  // An insert takes the lowest free cell; an extract frees the lowest cell
  // that holds the largest signed key.
  function automatic queue_word_t predict_word(logic op,
                                               logic signed [mpq_pkg::KEY_W-1:0] k);
    queue_word_t r;
    int pick;
    r.st = mpq_pkg::STAT_OK;
    r.mk = '0;
    pick = -1;
    if (op == mpq_pkg::FUNC_INSERT) begin
      for (int i = 0; i < mpq_pkg::CAPACITY; i++)
        if (!slot_used[i] && pick < 0) pick = i;
      if (fill >= mpq_pkg::CAPACITY || pick < 0) begin
        r.st = mpq_pkg::STAT_FULL;
      end else begin
        slot_key[pick]  = k;
        slot_used[pick] = 1'b1;
        fill++;
      end
    end else begin
      for (int i = 0; i < mpq_pkg::CAPACITY; i++)
        if (slot_used[i] && (pick < 0 || slot_key[i] > slot_key[pick])) pick = i;
      if (pick < 0) begin
        r.st = mpq_pkg::STAT_EMPTY;
      end else begin
        r.mk = slot_key[pick];
        slot_used[pick] = 1'b0;
        if (fill > 0) fill--;
      end
    end
    r.cnt = mpq_pkg::ECNT_W'(fill);
    return r;
  endfunction

  // Compare the result word of this cycle first, then record the command
  // word taken at the same edge.
  always @(posedge clk) begin
    queue_word_t want;
    if (rst) begin
      for (int i = 0; i < mpq_pkg::CAPACITY; i++) begin
        slot_used[i] = 1'b0;
        slot_key[i]  = '0;
      end
      fill = 0;
      expected_words.delete();
    end else begin
      if (done) begin
        if (expected_words.size() == 0) begin
          $error("result word with no command: status %0d max_key %0d entry_count %0d",
                 status, max_key, entry_count);
          fail_total++;
        end else begin
          want = expected_words.pop_front();
          checked_total++;
          if (status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status);
            fail_total++;
          end
          if (max_key !== want.mk) begin
            $error("max_key: expected %0d, got %0d", want.mk, max_key);
            fail_total++;
          end
          if (entry_count !== want.cnt) begin
            $error("entry_count: expected %0d, got %0d", want.cnt, entry_count);
            fail_total++;
          end
        end
      end
      if (start && !busy) begin
        want = predict_word(func, key);
        expected_words = {expected_words, want};
        if (want.st == mpq_pkg::STAT_EMPTY) empty_total++;
        if (want.st == mpq_pkg::STAT_FULL) full_total++;
        if (fill > peak_total) peak_total = fill;
      end
    end
    failures   <= fail_total;
    pending    <= expected_words.size();
    checked    <= checked_total;
    empty_hits <= empty_total;
    full_hits  <= full_total;
    peak_fill  <= peak_total;
  end

endmodule

/* bench/tb.sv */
// Top of the max priority queue bench: clock, reset and command words,
// with the checker beside the block giving the failure count for the verdict.
// Depends on mpq_pkg, max_priority_queue and mpq_monitor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 1750;
  localparam int QUIET_TAIL   = 250;
  localparam logic signed [mpq_pkg::KEY_W-1:0] KEY_MAX =
    {1'b0, {(mpq_pkg::KEY_W-1){1'b1}}};
  localparam logic signed [mpq_pkg::KEY_W-1:0] KEY_MIN =
    {1'b1, {(mpq_pkg::KEY_W-1){1'b0}}};

  logic                             clk;
  logic                             rst;
  logic                             start;
  logic                             busy;
  logic                             func;
  logic signed [mpq_pkg::KEY_W-1:0] key;
  logic                             done;
  logic [1:0]                       status;
  logic signed [mpq_pkg::KEY_W-1:0] max_key;
  logic [mpq_pkg::ECNT_W-1:0]       entry_count;
  int failures, pending, checked, empty_hits, full_hits, peak_fill;

  max_priority_queue dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func), .key(key),
    .done(done), .status(status), .max_key(max_key), .entry_count(entry_count)
  );

  mpq_monitor watch (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func), .key(key),
    .done(done), .status(status), .max_key(max_key), .entry_count(entry_count),
    .failures(failures), .pending(pending), .checked(checked),
    .empty_hits(empty_hits), .full_hits(full_hits), .peak_fill(peak_fill)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Hard stop in case the block stops answering.
  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

  // Presents one command word from a falling edge and holds it until it is
  // taken; returns at the next falling edge.
  task automatic issue(input logic op, input logic signed [mpq_pkg::KEY_W-1:0] k);
    start <= 1'b1;
    func  <= op;
    key   <= k;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Leaves start low for a burst of cycles, with junk on the other inputs.
  task automatic pause(input int cycles);
    start <= 1'b0;
    func  <= $urandom_range(0, 1);
    key   <= $urandom;
    repeat (cycles) @(negedge clk);
  endtask

  // Mostly random keys, some from a narrow range to force equal keys,
  // and some at the extremes.
  function automatic logic signed [mpq_pkg::KEY_W-1:0] pick_key();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) return $urandom;
    if (roll < 8) return $signed($urandom_range(0, 7)) - 4;
    case ($urandom_range(0, 3))
      0: return KEY_MAX;
      1: return KEY_MIN;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  initial begin
    int sent, seg_len, mode;
    bit idle_on;
    logic op;
    rst   = 1'b1;
    start = 1'b0;
    func  = mpq_pkg::FUNC_INSERT;
    key   = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Directed words: empty extract, extreme keys, equal keys, key ignored
    // on extract, alternating bit patterns.
    issue(mpq_pkg::FUNC_EXTRACT, '1);
    issue(mpq_pkg::FUNC_INSERT, KEY_MAX);
    issue(mpq_pkg::FUNC_INSERT, KEY_MIN);
    issue(mpq_pkg::FUNC_INSERT, '0);
    issue(mpq_pkg::FUNC_INSERT, '1);
    issue(mpq_pkg::FUNC_INSERT, 1);
    issue(mpq_pkg::FUNC_INSERT, 5);
    issue(mpq_pkg::FUNC_INSERT, 5);
    repeat (7) issue(mpq_pkg::FUNC_EXTRACT, KEY_MAX);
    issue(mpq_pkg::FUNC_EXTRACT, '0);
    issue(mpq_pkg::FUNC_INSERT, KEY_MIN);
    issue(mpq_pkg::FUNC_EXTRACT, '1);
    issue(mpq_pkg::FUNC_INSERT, 32'hAAAA_AAAA);
    issue(mpq_pkg::FUNC_INSERT, 32'h5555_5555);
    issue(mpq_pkg::FUNC_EXTRACT, '0);
    issue(mpq_pkg::FUNC_EXTRACT, '0);
    issue(mpq_pkg::FUNC_EXTRACT, '0);

    // Fill past capacity so inserts get dropped, then drain past empty.
    repeat (mpq_pkg::CAPACITY + 3) begin
      issue(mpq_pkg::FUNC_INSERT, pick_key());
      if ($urandom_range(0, 7) == 0) pause($urandom_range(1, 12));
    end
    repeat (mpq_pkg::CAPACITY + 2) begin
      issue(mpq_pkg::FUNC_EXTRACT, $urandom);
      if ($urandom_range(0, 7) == 0) pause($urandom_range(1, 12));
    end

    // Random segments, each leaning toward inserts, extracts or neither,
    // so the fill wanders across its whole range; the tail runs flat out.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      seg_len = $urandom_range(40, 150);
      mode    = $urandom_range(0, 2);
      idle_on = ($urandom_range(0, 3) != 0);
      for (int j = 0; j < seg_len && sent < RANDOM_WORDS; j++) begin
        if (sent >= RANDOM_WORDS - QUIET_TAIL) idle_on = 1'b0;
        case (mode)
          1: op = ($urandom_range(0, 9) < 8) ? mpq_pkg::FUNC_INSERT : mpq_pkg::FUNC_EXTRACT;
          2: op = ($urandom_range(0, 9) < 8) ? mpq_pkg::FUNC_EXTRACT : mpq_pkg::FUNC_INSERT;
          default: op = $urandom_range(0, 1) ? mpq_pkg::FUNC_EXTRACT : mpq_pkg::FUNC_INSERT;
        endcase
        issue(op, (op == mpq_pkg::FUNC_INSERT) ? pick_key() : $signed($urandom));
        sent++;
        if (idle_on && $urandom_range(0, 5) == 0) pause($urandom_range(1, 12));
      end
    end
    start <= 1'b0;

    // Let every outstanding result word arrive, then a few spare cycles.
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Checked %0d result words, %0d extracts on an empty queue,", checked, empty_hits);
    $display("%0d inserts dropped at full, peak fill %0d of %0d.", full_hits, peak_fill,
             mpq_pkg::CAPACITY);
    if (failures == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
